>>> rtl/rgbhsv_pkg.sv
// Shared types, constants and helper functions of the RGB to HSV converter.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    // Fixed field widths of a request and of a result.
    localparam int unsigned CHAN_W = 8;
    localparam int unsigned HUE_W  = 15;
    localparam int unsigned SAT_W  = 16;

    // Largest saturation that the result field can carry.
    localparam int unsigned SAT_MAX = 65535;

    // Hue numerator before angular scaling: at most eleven times the delta.
    localparam int unsigned NUM12_W = 12;

    // Angular constants: one sector is 60 degrees, six sectors make a turn.
    localparam int unsigned SECTOR_ANGLE = 60;
    localparam int unsigned SECTOR_COUNT = 6;
    localparam int unsigned SECTOR_ANGLE_W = 6;

    // The hue quotient stays below 660 degrees' worth of fraction units,
    // so it needs ten integer bits above the fraction.
    localparam int unsigned HUE_INT_BITS = 10;

    // Sector bases, already offset by six deltas so the numerator stays positive.
    localparam int unsigned BASE_W = 4;
    localparam logic [BASE_W-1:0] BASE_RED   = 4'd6;
    localparam logic [BASE_W-1:0] BASE_GREEN = 4'd8;
    localparam logic [BASE_W-1:0] BASE_BLUE  = 4'd10;

    // Queue between the classifying front and the arithmetic back.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } t_sector;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [CHAN_W-1:0] value;
    } t_hsv;

    // A classified pixel as it travels from the front to the back.
    typedef struct packed {
        logic [CHAN_W-1:0] max_chan;
        logic [CHAN_W-1:0] delta;
        t_sector           sector;
        logic [CHAN_W-1:0] plus_term;
        logic [CHAN_W-1:0] minus_term;
    } t_class;

    // Quotient width shared by both dividers, so that they have equal latency.
    function automatic int unsigned div_width(input int unsigned hue_frac_bits,
                                              input int unsigned sat_bits);
        int unsigned w;
        w = hue_frac_bits + HUE_INT_BITS;
        if (sat_bits > w) begin
            w = sat_bits;
        end
        return w;
    endfunction

endpackage

>>> rtl/rgbhsv_front.sv
// Front end: accepts pixel requests, finds the dominant channel and registers the class.
`timescale 1ns / 1ps

module rgbhsv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  rgbhsv_pkg::t_pixel  i_pixel,
    input  logic                i_full,
    output logic                o_busy,
    output logic                o_valid,
    output rgbhsv_pkg::t_class  o_item
);

    logic                            r_valid;
    logic                            n_valid;
    rgbhsv_pkg::t_class              r_item;
    rgbhsv_pkg::t_class              n_item;
    rgbhsv_pkg::t_class              w_class;
    logic [rgbhsv_pkg::CHAN_W-1:0]   w_min;

    // The held item can only leave when the queue has room.
    assign o_busy  = r_valid && i_full;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Ties go to red first, then to green.
    always_comb begin
        w_class = '0;
        if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue) begin
            w_class.sector     = rgbhsv_pkg::SECTOR_RED;
            w_class.max_chan   = i_pixel.red;
            w_class.plus_term  = i_pixel.green;
            w_class.minus_term = i_pixel.blue;
        end else if (i_pixel.green >= i_pixel.blue) begin
            w_class.sector     = rgbhsv_pkg::SECTOR_GREEN;
            w_class.max_chan   = i_pixel.green;
            w_class.plus_term  = i_pixel.blue;
            w_class.minus_term = i_pixel.red;
        end else begin
            w_class.sector     = rgbhsv_pkg::SECTOR_BLUE;
            w_class.max_chan   = i_pixel.blue;
            w_class.plus_term  = i_pixel.red;
            w_class.minus_term = i_pixel.green;
        end
        w_min = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        if (i_pixel.blue < w_min) begin
            w_min = i_pixel.blue;
        end
        w_class.delta = w_class.max_chan - w_min;
    end

    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (!o_busy) begin
            n_valid = i_start;
            n_item  = w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

>>> rtl/rgbhsv_queue.sv
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module rgbhsv_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgbhsv_pkg::t_class  i_item,
    output logic                o_full,
    output logic                o_valid,
    output rgbhsv_pkg::t_class  o_head
);

    localparam int unsigned AW    = rgbhsv_pkg::QUEUE_AW;
    localparam int unsigned DEPTH = rgbhsv_pkg::QUEUE_DEPTH;

    rgbhsv_pkg::t_class  r_mem [DEPTH];
    logic [AW-1:0]       r_wr_ptr;
    logic [AW-1:0]       n_wr_ptr;
    logic [AW-1:0]       r_rd_ptr;
    logic [AW-1:0]       n_rd_ptr;
    logic [AW:0]         r_count;
    logic [AW:0]         n_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // The back end never stalls, so the head leaves whenever it is present.
    assign w_push = i_push && !o_full;
    assign w_pop  = o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/rgbhsv_div.sv
// Pipelined restoring divider that retires one quotient bit per stage.
`timescale 1ns / 1ps

module rgbhsv_div #(
    parameter int unsigned QUO_W = 16,
    parameter int unsigned DEN_W = 8
) (
    input  logic                     i_clk,
    input  logic [DEN_W+QUO_W-1:0]   i_num,
    input  logic [DEN_W-1:0]         i_den,
    output logic [QUO_W-1:0]         o_quo
);

    localparam int unsigned NUM_W = DEN_W + QUO_W;

    // The caller guarantees that the top DEN_W numerator bits are below the divisor.
    logic [DEN_W-1:0]  r_rem     [QUO_W];
    logic [DEN_W-1:0]  r_den     [QUO_W];
    logic [QUO_W-1:0]  r_bits    [QUO_W];
    logic [DEN_W-1:0]  w_rem_in  [QUO_W];
    logic [DEN_W-1:0]  w_den_in  [QUO_W];
    logic [QUO_W-1:0]  w_bits_in [QUO_W];
    logic [DEN_W:0]    w_trial   [QUO_W];
    logic [QUO_W-1:0]  w_fit;
    logic [DEN_W-1:0]  n_rem     [QUO_W];
    logic [QUO_W-1:0]  n_bits    [QUO_W];

    always_comb begin
        w_rem_in[0]  = i_num[NUM_W-1 -: DEN_W];
        w_den_in[0]  = i_den;
        w_bits_in[0] = i_num[QUO_W-1:0];
        for (int k = 1; k < QUO_W; k++) begin
            w_rem_in[k]  = r_rem[k-1];
            w_den_in[k]  = r_den[k-1];
            w_bits_in[k] = r_bits[k-1];
        end
        for (int k = 0; k < QUO_W; k++) begin
            w_trial[k] = {w_rem_in[k], w_bits_in[k][QUO_W-1]};
            w_fit[k]   = (w_trial[k] >= {1'b0, w_den_in[k]});
            n_rem[k]   = w_fit[k] ? DEN_W'(w_trial[k] - {1'b0, w_den_in[k]})
                                  : w_trial[k][DEN_W-1:0];
            n_bits[k]  = {w_bits_in[k][QUO_W-2:0], w_fit[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QUO_W; k++) begin
            r_rem[k]  <= n_rem[k];
            r_den[k]  <= w_den_in[k];
            r_bits[k] <= n_bits[k];
        end
    end

    assign o_quo = r_bits[QUO_W-1];

endmodule

>>> rtl/rgbhsv_back.sv
// Back end: builds the numerators, divides, wraps the hue and registers the result.
`timescale 1ns / 1ps

module rgbhsv_back #(
    parameter int unsigned HUE_FRAC_BITS = 6,
    parameter int unsigned SAT_BITS      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  rgbhsv_pkg::t_class  i_item,
    output logic                o_strobe,
    output rgbhsv_pkg::t_hsv    o_result
);

    localparam int unsigned CHAN_W   = rgbhsv_pkg::CHAN_W;
    localparam int unsigned NUM12_W  = rgbhsv_pkg::NUM12_W;
    localparam int unsigned DIV_W    = rgbhsv_pkg::div_width(HUE_FRAC_BITS, SAT_BITS);
    localparam int unsigned NUM_W    = CHAN_W + DIV_W;
    localparam int unsigned UNIT     = rgbhsv_pkg::SECTOR_ANGLE << HUE_FRAC_BITS;
    localparam int unsigned UNIT_W   = rgbhsv_pkg::SECTOR_ANGLE_W + HUE_FRAC_BITS;
    localparam int unsigned PROD_W   = NUM12_W + UNIT_W;
    localparam int unsigned HUE_FULL = UNIT * rgbhsv_pkg::SECTOR_COUNT;

    // First stage: sector numerator and saturation numerator.
    logic                           r_s1_valid;
    logic [NUM12_W-1:0]             r_s1_hue_num;
    logic [NUM_W-1:0]               r_s1_sat_num;
    logic [CHAN_W-1:0]              r_s1_max;
    logic [CHAN_W-1:0]              r_s1_delta;
    logic [NUM12_W-1:0]             n_s1_hue_num;
    logic [NUM_W-1:0]               n_s1_sat_num;
    logic [rgbhsv_pkg::BASE_W-1:0]  w_base;

    // Second stage: hue numerator scaled to fraction units.
    logic                           r_s2_valid;
    logic [NUM_W-1:0]               r_s2_hue_num;
    logic [NUM_W-1:0]               r_s2_sat_num;
    logic [CHAN_W-1:0]              r_s2_max;
    logic [CHAN_W-1:0]              r_s2_delta;
    logic [NUM_W-1:0]               n_s2_hue_num;

    // Side line that keeps value and special-case flags level with the dividers.
    logic [DIV_W-1:0]               r_vld_line;
    logic [DIV_W-1:0]               r_gray_line;
    logic [DIV_W-1:0]               r_black_line;
    logic [CHAN_W-1:0]              r_val_line [DIV_W];

    logic [DIV_W-1:0]               w_hue_quo;
    logic [DIV_W-1:0]               w_sat_quo;
    logic [DIV_W-1:0]               w_hue_mod;

    logic                           r_strobe;
    logic                           n_strobe;
    rgbhsv_pkg::t_hsv               r_result;
    rgbhsv_pkg::t_hsv               n_result;

    always_comb begin
        unique case (i_item.sector)
            rgbhsv_pkg::SECTOR_RED:   w_base = rgbhsv_pkg::BASE_RED;
            rgbhsv_pkg::SECTOR_GREEN: w_base = rgbhsv_pkg::BASE_GREEN;
            rgbhsv_pkg::SECTOR_BLUE:  w_base = rgbhsv_pkg::BASE_BLUE;
            default:                  w_base = rgbhsv_pkg::BASE_RED;
        endcase
        n_s1_hue_num = NUM12_W'(NUM12_W'(w_base) * NUM12_W'(i_item.delta))
                     + NUM12_W'(i_item.plus_term) - NUM12_W'(i_item.minus_term);
        // delta * (2^SAT_BITS - 1) without a multiplier
        n_s1_sat_num = (NUM_W'(i_item.delta) << SAT_BITS) - NUM_W'(i_item.delta);
    end

    always_ff @(posedge i_clk) begin
        r_s1_hue_num <= n_s1_hue_num;
        r_s1_sat_num <= n_s1_sat_num;
        r_s1_max     <= i_item.max_chan;
        r_s1_delta   <= i_item.delta;
    end

    assign n_s2_hue_num = NUM_W'(PROD_W'(r_s1_hue_num) * PROD_W'(UNIT));

    always_ff @(posedge i_clk) begin
        r_s2_hue_num <= n_s2_hue_num;
        r_s2_sat_num <= r_s1_sat_num;
        r_s2_max     <= r_s1_max;
        r_s2_delta   <= r_s1_delta;
    end

    rgbhsv_div #(
        .QUO_W (DIV_W),
        .DEN_W (CHAN_W)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_num (r_s2_hue_num),
        .i_den (r_s2_delta),
        .o_quo (w_hue_quo)
    );

    rgbhsv_div #(
        .QUO_W (DIV_W),
        .DEN_W (CHAN_W)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_num (r_s2_sat_num),
        .i_den (r_s2_max),
        .o_quo (w_sat_quo)
    );

    always_ff @(posedge i_clk) begin
        r_gray_line  <= {r_gray_line[DIV_W-2:0], (r_s2_delta == '0)};
        r_black_line <= {r_black_line[DIV_W-2:0], (r_s2_max == '0)};
        r_val_line[0] <= r_s2_max;
        for (int k = 1; k < DIV_W; k++) begin
            r_val_line[k] <= r_val_line[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_vld_line <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_vld_line <= {r_vld_line[DIV_W-2:0], r_s2_valid};
        end
    end

    // The quotient lies below two full turns, so one subtraction wraps it.
    always_comb begin
        if (w_hue_quo >= DIV_W'(HUE_FULL)) begin
            w_hue_mod = w_hue_quo - DIV_W'(HUE_FULL);
        end else begin
            w_hue_mod = w_hue_quo;
        end
        n_strobe       = r_vld_line[DIV_W-1];
        n_result.value = r_val_line[DIV_W-1];
        if (r_gray_line[DIV_W-1]) begin
            n_result.hue = '0;
        end else begin
            n_result.hue = rgbhsv_pkg::HUE_W'(w_hue_mod);
        end
        if (r_black_line[DIV_W-1]) begin
            n_result.saturation = '0;
        end else if (32'(w_sat_quo) > 32'(rgbhsv_pkg::SAT_MAX)) begin
            n_result.saturation = rgbhsv_pkg::SAT_W'(rgbhsv_pkg::SAT_MAX);
        end else begin
            n_result.saturation = rgbhsv_pkg::SAT_W'(w_sat_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> rtl/rgb_to_hsv_converter_unit.sv
// RGB to HSV converter top level: front end, request queue and pipelined back end.
// Throughput is one request per clock; the result strobe follows an accepted request
// through the front register, queue, numerator stages, dividers and output register.
// DIV_W = max(SAT_BITS, HUE_FRAC_BITS + 10) is the depth of the two bit-per-stage dividers.
// Reset is synchronous and active low; it empties the queue and every valid stage.
// Results cannot be held off by the receiver, so the pipeline never stalls.
`timescale 1ns / 1ps

module rgb_to_hsv_converter_unit #(
    parameter int unsigned HUE_FRAC_BITS = 6,
    parameter int unsigned SAT_BITS      = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  rgbhsv_pkg::t_pixel  i_pixel,
    output logic                busy,
    output logic                o_strobe,
    output rgbhsv_pkg::t_hsv    o_result
);

    // Depth of the dividers in the back end and the resulting request-to-strobe delay:
    // the front register loads at the accepting edge itself, then the request passes the
    // queue, two numerator stages, DIV_W divider stages and the output register.
    localparam int unsigned DIV_W    = rgbhsv_pkg::div_width(HUE_FRAC_BITS, SAT_BITS);
    localparam int unsigned LATENCY  = DIV_W + 5;
    localparam int unsigned HUE_FULL = (rgbhsv_pkg::SECTOR_ANGLE << HUE_FRAC_BITS)
                                     * rgbhsv_pkg::SECTOR_COUNT;
    localparam bit          HUE_FITS = (HUE_FULL <= (1 << rgbhsv_pkg::HUE_W));

    logic                front_valid;
    rgbhsv_pkg::t_class  front_item;
    logic                queue_full;
    logic                queue_valid;
    rgbhsv_pkg::t_class  queue_head;
    logic                accept;

    assign accept = start && !busy;

    // The front end finds the dominant channel, its sector and the delta, and holds
    // the classified request until the queue has room for it.
    rgbhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_pixel (i_pixel),
        .i_full  (queue_full),
        .o_busy  (busy),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    // The queue decouples the two halves; the back end drains its head every cycle.
    rgbhsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_head  (queue_head)
    );

    // The back end forms both numerators, runs the two dividers side by side, wraps
    // the hue into one turn and applies the grey and black pixel cases.
    rgbhsv_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .SAT_BITS      (SAT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_valid),
        .i_item   (queue_head),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Every accepted request produces its result after the fixed pipeline delay.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted request did not produce a result on time");

    // The back end drains the queue every cycle, so requests are never held off.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("front end stalled although the back end never stalls");

    // A black pixel has no saturation.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.value == '0) |-> (o_result.saturation == '0))
        else $error("black pixel reported with non-zero saturation");

    // The hue always lies within one turn when a turn fits the field.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && HUE_FITS |-> (32'(o_result.hue) < HUE_FULL))
        else $error("hue outside one full turn");

endmodule

>>> dv/hsv_result_checker.sv
// Checker that predicts each HSV result from the accepted pixel requests and compares it.
`timescale 1ns / 1ps

module hsv_result_checker #(
    parameter int unsigned HUE_FRAC_BITS = 6,
    parameter int unsigned SAT_BITS      = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  rgbhsv_pkg::t_pixel i_pixel,
    input  logic               i_strobe,
    input  rgbhsv_pkg::t_hsv   i_result,
    output int                 o_fail_count,
    output int                 o_pending
);

    rgbhsv_pkg::t_hsv expected_hsv_q[$];
    int               mismatch_count = 0;

    // Fixed-point hue, saturation and value of one pixel.
    function automatic rgbhsv_pkg::t_hsv predict_hsv(input rgbhsv_pkg::t_pixel px);
        logic [7:0]          r;
        logic [7:0]          g;
        logic [7:0]          b;
        logic [7:0]          mx;
        logic [7:0]          mn;
        logic [7:0]          delta;
        logic [63:0]         unit;
        logic [63:0]         full;
        logic [63:0]         num;
        logic [63:0]         hue;
        logic [63:0]         sat;
        rgbhsv_pkg::t_sector sector;
        rgbhsv_pkg::t_hsv    res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        unit = 64'd60 << HUE_FRAC_BITS;
        full = unit * 64'd6;
        sat = '0;
        hue = '0;
        if (mx != 8'd0) begin
            sat = (64'(delta) * ((64'd1 << SAT_BITS) - 64'd1)) / 64'(mx);
            if (sat > 64'd65535) sat = 64'd65535;
        end
        if (delta != 8'd0) begin
            // Ties go to red first, then green.
            if (r == mx) begin
                sector = rgbhsv_pkg::SECTOR_RED;
            end else if (g == mx) begin
                sector = rgbhsv_pkg::SECTOR_GREEN;
            end else begin
                sector = rgbhsv_pkg::SECTOR_BLUE;
            end
            // Bases carry an extra six deltas so that the numerator never goes negative,
            // which makes truncating division act as floor division.
            case (sector)
                rgbhsv_pkg::SECTOR_RED:   num = 64'(delta) * 64'd6 + 64'(g) - 64'(b);
                rgbhsv_pkg::SECTOR_GREEN: num = 64'(delta) * 64'd8 + 64'(b) - 64'(r);
                default:                  num = 64'(delta) * 64'd10 + 64'(r) - 64'(g);
            endcase
            hue = (num * unit) / 64'(delta);
            hue = hue % full;
        end
        res.hue        = hue[14:0];
        res.saturation = sat[15:0];
        res.value      = mx;
        return res;
    endfunction

    task automatic report_field(input string field, input int unsigned exp_val,
                                input int unsigned act_val);
        if (exp_val != act_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $realtime, field, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        rgbhsv_pkg::t_hsv want;
        if (!i_rst_n) begin
            expected_hsv_q.delete();
        end else begin
            if (i_strobe) begin
                if (expected_hsv_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                             $realtime, i_result.hue, i_result.saturation, i_result.value);
                end else begin
                    want = expected_hsv_q.pop_front();
                    report_field("hue", want.hue, i_result.hue);
                    report_field("saturation", want.saturation, i_result.saturation);
                    report_field("value", want.value, i_result.value);
                end
            end
            if (i_start && !i_busy) begin
                expected_hsv_q.push_back(predict_hsv(i_pixel));
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_hsv_q.size();
    end

endmodule

>>> dv/tb_rgb_to_hsv_converter_unit.sv
// Testbench top: drives pixel requests into the converter and gives the verdict.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;

    localparam int unsigned HUE_FRAC_BITS = 6;
    localparam int unsigned SAT_BITS      = 16;
    localparam int unsigned CLK_PERIOD    = 8;
    localparam int unsigned RESET_CYCLES  = 9;
    localparam int unsigned RANDOM_ITEMS  = 1300;
    // The tail after the last result comfortably covers anything still in flight.
    localparam int unsigned TAIL_CYCLES   = 50;
    // The longest quiet spell of a correct run is a sender gap or a pipeline drain,
    // both far shorter than this limit.
    localparam int unsigned STALL_LIMIT   = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    rgbhsv_pkg::t_pixel i_pixel;
    logic               busy;
    logic               o_strobe;
    rgbhsv_pkg::t_hsv   o_result;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    rgb_to_hsv_converter_unit #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .SAT_BITS     (SAT_BITS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_pixel (i_pixel),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    hsv_result_checker #(
        .HUE_FRAC_BITS(HUE_FRAC_BITS),
        .SAT_BITS     (SAT_BITS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_pixel     (i_pixel),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Builds a pixel from three channel bytes.
    function automatic rgbhsv_pkg::t_pixel make_pixel(input logic [7:0] r,
                                                      input logic [7:0] g,
                                                      input logic [7:0] b);
        rgbhsv_pkg::t_pixel px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // A random pixel, weighted towards the corners of the conversion: ties for the
    // largest channel, gray pixels, saturated extremes and very small deltas.
    function automatic rgbhsv_pkg::t_pixel random_pixel();
        logic [7:0]         top_chan;
        logic [7:0]         lo_chan;
        logic [7:0]         near_vals [4];
        rgbhsv_pkg::t_pixel px;
        near_vals[0] = 8'd0;
        near_vals[1] = 8'd1;
        near_vals[2] = 8'd254;
        near_vals[3] = 8'd255;
        top_chan = 8'($urandom_range(0, 255));
        lo_chan  = 8'($urandom_range(0, top_chan));
        px = make_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        case ($urandom_range(0, 9))
            4: begin
                // Two channels share the maximum; the third is at or below it.
                case ($urandom_range(0, 2))
                    0: px = make_pixel(top_chan, top_chan, lo_chan);
                    1: px = make_pixel(top_chan, lo_chan, top_chan);
                    default: px = make_pixel(lo_chan, top_chan, top_chan);
                endcase
            end
            5: px = make_pixel(top_chan, top_chan, top_chan);
            6: px = make_pixel(near_vals[$urandom_range(0, 3)], near_vals[$urandom_range(0, 3)],
                               near_vals[$urandom_range(0, 3)]);
            7: px = make_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                               8'($urandom_range(0, 3)));
            8: begin
                // Delta of two or less if top_chan > 2, so the hue lands on sector edges.
                lo_chan = (top_chan > 8'd2) ? top_chan - 8'($urandom_range(0, 2)) : top_chan;
                case ($urandom_range(0, 2))
                    0: px = make_pixel(top_chan, lo_chan, top_chan - 8'($urandom_range(0, 2)));
                    1: px = make_pixel(lo_chan, top_chan, top_chan - 8'($urandom_range(0, 2)));
                    default: px = make_pixel(lo_chan, top_chan - 8'($urandom_range(0, 2)),
                                             top_chan);
                endcase
            end
            default: ;
        endcase
        return px;
    endfunction

    // Holds one request on the inputs until the converter takes it. Start is left high,
    // so a following request in the same burst goes out on the very next cycle.
    task automatic send_pixel(input rgbhsv_pkg::t_pixel px);
        start   <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // A gap in the request stream; the pixel bus carries junk while start is low.
    task automatic idle_for(input int unsigned cycles);
        if (cycles != 0) begin
            start <= 1'b0;
            repeat (cycles) begin
                i_pixel <= make_pixel(8'($urandom), 8'($urandom), 8'($urandom));
                @(posedge i_clk);
            end
        end
    endtask

    // Stops the stream and waits until every predicted result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Watchdog: the run is abandoned after too many cycles with neither a request
    // nor a result accepted.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("tb_rgb_to_hsv_converter_unit: done, errors");
        $finish;
    end

    initial begin
        int unsigned sent;
        int unsigned burst;
        bit          drained;
        sent    = 0;
        drained = 1'b0;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_pixel = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests: black, white and gray pixels, the primaries and secondaries,
        // the tie order between channels, and pixels either side of the hue wrap.
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd128, 8'd128, 8'd128));
        send_pixel(make_pixel(8'd1, 8'd1, 8'd1));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd1, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd1, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd1));
        idle_for(3);
        send_pixel(make_pixel(8'd255, 8'd0, 8'd1));
        send_pixel(make_pixel(8'd255, 8'd1, 8'd0));
        send_pixel(make_pixel(8'd254, 8'd255, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd255, 8'd254));
        send_pixel(make_pixel(8'd1, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd0, 8'd1, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd254, 8'd254));
        send_pixel(make_pixel(8'd1, 8'd0, 8'd1));
        send_pixel(make_pixel(8'd0, 8'd1, 8'd1));
        send_pixel(make_pixel(8'd170, 8'd85, 8'd0));
        drain_results();

        // Random requests in bursts of random length. Gaps of zero give long stretches
        // with no idling at all; once, part way through, the stream drains fully.
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 48);
            for (int unsigned n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
                send_pixel(random_pixel());
                sent++;
            end
            if (!drained && sent >= RANDOM_ITEMS / 2) begin
                drain_results();
                drained = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                idle_for(0);
            end else if ($urandom_range(0, 1) == 0) begin
                idle_for($urandom_range(1, 6));
            end else begin
                idle_for($urandom_range(7, 40));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_rgb_to_hsv_converter_unit: done, clean");
        end else begin
            $display("tb_rgb_to_hsv_converter_unit: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_front.sv
rtl/rgbhsv_queue.sv
rtl/rgbhsv_div.sv
rtl/rgbhsv_back.sv
rtl/rgb_to_hsv_converter_unit.sv
dv/hsv_result_checker.sv
dv/tb_rgb_to_hsv_converter_unit.sv
